/* rtl/rld_pkg.sv */
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run-length decoder with literal runs.
// ----------------------------------------------------------------------------
package rld_pkg;

  // Width of one stream word and of one decoded symbol.
  localparam int WordW = 16;

  // Default limit on a repeat header; headers above it are flagged.
  localparam int MaxRunDefault = 64;

  // Controller states.
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_COUNT,
    ST_LITERAL,
    ST_SYMBOL,
    ST_REPEAT
  } rld_state_t;

  // Source of the payload loaded into the output register.
  typedef enum logic [1:0] {
    OUT_WORD,
    OUT_HELD,
    OUT_ERROR
  } rld_out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_count;
    logic         dec_count;
    logic         capture_sym;
    logic         out_load;
    rld_out_sel_t out_sel;
    logic         out_last;
  } rld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_zero;
    logic word_over;
    logic count_one;
    logic slot_free;
  } rld_status_t;

endpackage

/* rtl/rld_in_if.sv */
// ----------------------------------------------------------------------------
// rld_in_if
// Input channel: one compressed code word per transaction.
// ----------------------------------------------------------------------------
interface rld_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;

  modport source (output valid, output code_word, input ready);
  modport sink (input valid, input code_word, output ready);
endinterface

/* rtl/rld_out_if.sv */
// ----------------------------------------------------------------------------
// rld_out_if
// Output channel: one decoded symbol with its flags per transaction.
// ----------------------------------------------------------------------------
interface rld_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] symbol;
  logic        last_of_run;
  logic        error;

  modport source (output valid, output symbol, output last_of_run, output error,
                  input ready);
  modport sink (input valid, input symbol, input last_of_run, input error,
                output ready);
endinterface

/* rtl/rld_datapath.sv */
// ----------------------------------------------------------------------------
// rld_datapath
// Count and symbol registers, word classification and the output register.
// ----------------------------------------------------------------------------
module rld_datapath #(
  parameter int MAX_RUN = rld_pkg::MaxRunDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rld_pkg::WordW-1:0] code_word,
  input  rld_pkg::rld_cmd_t         cmd,
  output rld_pkg::rld_status_t      status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rld_pkg::WordW-1:0] out_symbol,
  output logic                      out_last,
  output logic                      out_error
);
  import rld_pkg::*;

  localparam logic [WordW-1:0] MaxRunW = WordW'(MAX_RUN);

  logic [WordW-1:0] count;
  logic [WordW-1:0] held_sym;

  // Classification of the incoming word and of the remaining count.
  always_comb begin
    status.word_zero = (code_word == '0);
    status.word_over = (code_word > MaxRunW);
    status.count_one = (count == WordW'(1));
    status.slot_free = !out_valid || out_ready;
  end

  // Remaining literal or repeat count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_count) begin
      count <= code_word;
    end else if (cmd.dec_count) begin
      count <= count - WordW'(1);
    end
  end

  // Symbol held for the rest of a repeat run.
  always_ff @(posedge clk) begin
    if (cmd.capture_sym) begin
      held_sym <= code_word;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_WORD: begin
          out_symbol <= code_word;
          out_last   <= cmd.out_last;
          out_error  <= 1'b0;
        end
        OUT_HELD: begin
          out_symbol <= held_sym;
          out_last   <= cmd.out_last;
          out_error  <= 1'b0;
        end
        OUT_ERROR: begin
          out_symbol <= '0;
          out_last   <= 1'b1;
          out_error  <= 1'b1;
        end
        default: begin
          out_symbol <= '0;
          out_last   <= 1'b1;
          out_error  <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/rld_ctrl.sv */
// ----------------------------------------------------------------------------
// rld_ctrl
// Decode state machine: classifies each word by phase and steers the datapath.
// ----------------------------------------------------------------------------
module rld_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rld_pkg::rld_status_t status,
  output rld_pkg::rld_cmd_t    cmd
);
  import rld_pkg::*;

  rld_state_t state;
  rld_state_t state_next;
  logic       accept;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    cmd.load_count  = 1'b0;
    cmd.dec_count   = 1'b0;
    cmd.capture_sym = 1'b0;
    cmd.out_load    = 1'b0;
    cmd.out_sel     = OUT_WORD;
    cmd.out_last    = 1'b1;
    in_ready        = (state != ST_REPEAT) && status.slot_free;
    accept          = in_valid && in_ready;

    case (state)
      ST_HEADER: begin
        if (accept) begin
          if (status.word_zero) begin
            state_next = ST_COUNT;
          end else if (status.word_over) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = OUT_ERROR;
          end else begin
            cmd.load_count = 1'b1;
            state_next     = ST_SYMBOL;
          end
        end
      end
      ST_COUNT: begin
        if (accept && !status.word_zero) begin
          cmd.load_count = 1'b1;
          state_next     = ST_LITERAL;
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_WORD;
          cmd.dec_count = 1'b1;
          if (status.count_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_SYMBOL: begin
        // The first result of the run leaves with the symbol word itself.
        if (accept) begin
          cmd.capture_sym = 1'b1;
          cmd.out_load    = 1'b1;
          cmd.out_sel     = OUT_WORD;
          cmd.out_last    = status.count_one;
          cmd.dec_count   = 1'b1;
          state_next      = status.count_one ? ST_HEADER : ST_REPEAT;
        end
      end
      ST_REPEAT: begin
        if (status.slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_HELD;
          cmd.out_last  = status.count_one;
          cmd.dec_count = 1'b1;
          if (status.count_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase
  end

endmodule

/* rtl/rle_literal_run_decoder.sv */
// ----------------------------------------------------------------------------
// rle_literal_run_decoder
// Expands a stream of 16-bit code words made of repeat runs and literal blocks.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                          Meaning
//   din      in         code_word[15:0]                  header, count, symbol
//                                                        or literal word
//   dout     out        symbol[15:0], last_of_run, error one decoded symbol
//
// A literal word gives one transaction on dout. A repeat symbol of run length
// N gives N copies: the symbol word leaves with the first copy, and din is held
// off for the rest of the run while the single output register sends one copy
// per cycle when dout is not stalled.
// Reset is synchronous and returns the decoder to waiting for a header.
// A stall on dout holds the output register and stops din as well.
//
module rle_literal_run_decoder #(
  parameter int MAX_RUN = rld_pkg::MaxRunDefault
) (
  input  logic       clk,
  input  logic       rst,
  rld_in_if.sink     din,
  rld_out_if.source  dout
);
  import rld_pkg::*;

  rld_cmd_t    cmd;
  rld_status_t status;

  // Decode state machine.
  rld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers and output stage.
  rld_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .code_word  (din.code_word),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .out_symbol (dout.symbol),
    .out_last   (dout.last_of_run),
    .out_error  (dout.error)
  );

endmodule

/* tb/tb_rle_literal_run_decoder.sv */
// ----------------------------------------------------------------------------
// tb_rle_literal_run_decoder
// Self-checking bench for the run-length decoder with literal runs.
// ----------------------------------------------------------------------------
// A stream of code words is built up front. It opens with a directed list:
// the shortest and longest repeat runs, oversized headers, zero literal
// counts and extreme symbol values. After that come random repeat runs,
// literal blocks, oversized headers and some broken sequences.
// A clocked driver sends the words with random gaps. A clocked monitor
// expands every accepted word into the decoded symbols it should produce and
// checks each output transaction against the oldest one of them. The output
// side stalls at random. A watchdog ends the run if no transaction is
// accepted on either channel for too long.
// ----------------------------------------------------------------------------
module tb_rle_literal_run_decoder;
  import rld_pkg::*;

  localparam int RunLimit      = MaxRunDefault;
  localparam int RandomWords   = 330;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = RunLimit + 16;

  // One decoded symbol together with its flags.
  typedef struct packed {
    logic [WordW-1:0] symbol;
    logic             last_of_run;
    logic             error;
  } decoded_t;

  logic clk;
  logic rst;

  rld_in_if  din_if ();
  rld_out_if dout_if ();

  rle_literal_run_decoder #(
    .MAX_RUN(RunLimit)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if)
  );

  // Stream words still to be sent, and decoded symbols still to arrive.
  logic [WordW-1:0] stream_q[$];
  decoded_t         decoded_q[$];

  // Decoder state as the checker sees it.
  rld_state_t       exp_phase;
  logic [WordW-1:0] exp_count;

  // Run statistics and error bookkeeping.
  int  words_sent;
  int  symbols_checked;
  int  runs_expanded;
  int  literals_passed;
  int  oversized_headers;
  int  mismatches;
  int  idle_cycles;
  bit  in_accepted;
  bit  calm;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draws a gap length: mostly short, now and then long.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Appends one word to the outgoing stream.
  function automatic void push_word(input logic [WordW-1:0] w);
    stream_q.insert(stream_q.size(), w);
  endfunction

  // Appends one decoded symbol to the list of expected results.
  function automatic void expect_symbol(input decoded_t d);
    decoded_q.insert(decoded_q.size(), d);
  endfunction

  // Appends a complete repeat run: header and symbol.
  function automatic void push_repeat(input int len, input logic [WordW-1:0] sym);
    push_word(WordW'(len));
    push_word(sym);
  endfunction

  // Appends a literal block, optionally with zero counts before the real one.
  function automatic void push_literals(input int zeros, input int len, input int sent);
    push_word('0);
    for (int i = 0; i < zeros; i++) push_word('0);
    push_word(WordW'(len));
    for (int i = 0; i < sent; i++) push_word(WordW'($urandom));
  endfunction

  // Expands one accepted code word into the symbols the decoder must emit.
  function automatic void expand_word(input logic [WordW-1:0] w);
    decoded_t d;
    case (exp_phase)
      ST_HEADER: begin
        if (w == '0) begin
          exp_phase = ST_COUNT;
        end else if (int'(w) > RunLimit) begin
          d = '{symbol: '0, last_of_run: 1'b1, error: 1'b1};
          expect_symbol(d);
          oversized_headers++;
        end else begin
          exp_count = w;
          exp_phase = ST_SYMBOL;
        end
      end
      ST_COUNT: begin
        // A zero count leaves the decoder waiting for another count.
        if (w != '0) begin
          exp_count = w;
          exp_phase = ST_LITERAL;
        end
      end
      ST_LITERAL: begin
        d = '{symbol: w, last_of_run: 1'b1, error: 1'b0};
        expect_symbol(d);
        literals_passed++;
        exp_count = exp_count - WordW'(1);
        if (exp_count == '0) exp_phase = ST_HEADER;
      end
      default: begin
        for (int k = 0; k < int'(exp_count); k++) begin
          d = '{symbol: w, last_of_run: (k == int'(exp_count) - 1), error: 1'b0};
          expect_symbol(d);
        end
        runs_expanded++;
        exp_count = '0;
        exp_phase = ST_HEADER;
      end
    endcase
  endfunction

  // Input driver: holds a word until it is accepted, then waits out a gap.
  always @(negedge clk) begin : drive_words
    int               gap_left;
    logic             next_valid;
    logic [WordW-1:0] next_word;
    next_valid = din_if.valid;
    next_word  = din_if.code_word;
    if (rst) begin
      next_valid = 1'b0;
      gap_left   = 0;
    end else if (!din_if.valid || in_accepted) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (stream_q.size() != 0) begin
        next_word  = stream_q.pop_front();
        next_valid = 1'b1;
        words_sent++;
        // Every fifty words the bench switches between random gaps and full rate.
        if (words_sent % 50 == 0) calm = !calm;
        gap_left = calm ? 0 : gap_length();
      end
    end
    din_if.valid     <= next_valid;
    din_if.code_word <= next_word;
  end

  // Output back-pressure: random stalls, none while the bench runs calm.
  always @(negedge clk) begin : drive_ready
    int   stall_left;
    logic next_ready;
    if (rst || calm) begin
      next_ready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      next_ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 25) begin
      next_ready = 1'b0;
      stall_left = gap_length();
    end else begin
      next_ready = 1'b1;
    end
    dout_if.ready <= next_ready;
  end

  // Monitor: predicts on accepted words, checks accepted symbols, and
  // watches for a hang.
  always @(posedge clk) begin : monitor
    decoded_t got;
    decoded_t want;
    bit       moved;
    in_accepted = 1'b0;
    moved       = 1'b0;
    if (!rst) begin
      if (din_if.valid && din_if.ready) begin
        in_accepted = 1'b1;
        moved       = 1'b1;
        expand_word(din_if.code_word);
      end
      if (dout_if.valid && dout_if.ready) begin
        moved = 1'b1;
        got   = '{symbol: dout_if.symbol, last_of_run: dout_if.last_of_run,
                  error: dout_if.error};
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected output symbol=%h last=%b error=%b",
                     got.symbol, got.last_of_run, got.error);
        end else begin
          want = decoded_q.pop_front();
          symbols_checked++;
          if (got.symbol !== want.symbol || got.last_of_run !== want.last_of_run ||
              got.error !== want.error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: output %0d expected symbol=%h last=%b error=%b,",
                       symbols_checked, want.symbol, want.last_of_run, want.error);
              $display("       got symbol=%h last=%b error=%b",
                       got.symbol, got.last_of_run, got.error);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("ERROR: no transaction for %0d cycles, %0d symbols outstanding",
                 idle_cycles, decoded_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of test.
  initial begin : stimulus
    int kind;
    int len;
    rst               = 1'b1;
    din_if.valid      = 1'b0;
    din_if.code_word  = '0;
    dout_if.ready     = 1'b0;
    exp_phase         = ST_HEADER;
    exp_count         = '0;
    words_sent        = 0;
    symbols_checked   = 0;
    runs_expanded     = 0;
    literals_passed   = 0;
    oversized_headers = 0;
    mismatches        = 0;
    idle_cycles       = 0;
    in_accepted       = 1'b0;
    calm              = 1'b0;

    // Directed part: run length extremes, oversized headers, zero literal
    // counts and extreme word values.
    push_repeat(1, 16'h0000);
    push_repeat(RunLimit, 16'hFFFF);
    push_word(WordW'(RunLimit + 1));
    push_word(16'hFFFF);
    push_word(16'h8000);
    push_word('0);
    push_word('0);
    push_word('0);
    push_word(16'd2);
    push_word(16'hFFFF);
    push_word(16'h0000);
    push_literals(0, 1, 1);
    push_repeat(2, 16'h8001);
    push_repeat(RunLimit - 1, 16'h7FFE);
    push_literals(0, 3, 3);

    // Random part: mostly well-formed runs and blocks, some broken ones.
    while (stream_q.size() < RandomWords) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, RunLimit)
                                          : $urandom_range(1, 8);
        push_repeat(len, WordW'($urandom));
      end else if (kind < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                          : $urandom_range(1, 6);
        push_literals(($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0, len, len);
      end else if (kind < 88) begin
        push_word(WordW'($urandom_range(RunLimit + 1, 65535)));
      end else if (kind < 94) begin
        // A literal block cut short; later headers are taken as literals.
        len = $urandom_range(2, 6);
        push_literals(0, len, $urandom_range(0, len - 1));
      end else begin
        // A lone random header word; if it names a repeat run, the next word becomes its symbol.
        push_word(WordW'($urandom));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (stream_q.size() != 0 || din_if.valid || decoded_q.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d code words: %0d repeat runs, %0d literals, %0d oversized headers.",
             words_sent, runs_expanded, literals_passed, oversized_headers);
    $display("Checked %0d decoded symbols, %0d mismatches, %0d left over.",
             symbols_checked, mismatches, decoded_q.size());
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rld_pkg.sv
rtl/rld_in_if.sv
rtl/rld_out_if.sv
rtl/rld_datapath.sv
rtl/rld_ctrl.sv
rtl/rle_literal_run_decoder.sv
tb/tb_rle_literal_run_decoder.sv
